// ===== design/fmdsb_pkg.sv =====
// shared types and helpers for the four-mic delay-and-sum beamformer
package fmdsb_pkg;

   localparam int MICS      = 4;
   localparam int SAMPLE_W  = 32;
   localparam int GAIN_W    = 17;
   localparam int DELAY_W   = 14;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 17;
   localparam int GAIN_SHIFT = 15;
   localparam int ALPHA_SHIFT = 31;
   // delay line geometry, tied to the delay register width
   localparam int LINE_LENGTH   = 64;
   localparam int FRACTION_BITS = 8;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [GAIN_W-1:0]   gain_type;
   typedef logic [DELAY_W-1:0]         delay_type;

   typedef struct packed {
      sample_type mic0_sample;
      sample_type mic1_sample;
      sample_type mic2_sample;
      sample_type mic3_sample;
   } req_payload_type;

   typedef struct packed {
      sample_type beam_sample;
   } rsp_payload_type;

   // saturate a 64-bit signed value to 32 bits
   function automatic sample_type sat32(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (v > hi) return sample_type'(hi);
      if (v < lo) return sample_type'(lo);
      return v[SAMPLE_W-1:0];
   endfunction

endpackage

// ===== design/fmdsb_stream_if.sv =====
// valid/ready stream interface
interface fmdsb_stream_if #(parameter int WIDTH = 32);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/fmdsb_ram.sv =====
// generic simple dual-port ram (one write port, one read port) with registered read
module fmdsb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== design/fmdsb_mac.sv =====
// shared signed multiply with half-away rounding shift, registered
module fmdsb_mac (
   input  logic               clock,
   input  logic signed [32:0] op_a,
   input  logic signed [32:0] op_b,
   input  logic [4:0]         shift,
   output logic signed [63:0] prod_ff,
   output logic signed [63:0] result
);
   import fmdsb_pkg::*;
   logic [63:0] mag;
   logic [63:0] rnd;
   logic [63:0] sh;

   always_ff @(posedge clock) begin
      prod_ff <= 64'(op_a * op_b);
   end

   // round half away from zero on the registered product
   always_comb begin
      mag = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
      rnd = 64'(1) << (shift - 5'd1);
      sh  = (mag + rnd) >> shift;
      result = prod_ff[63] ? -$signed(sh) : $signed(sh);
   end
endmodule

// ===== design/four_mic_delay_sum_beamformer_core.sv =====
// top level of the four-microphone delay-and-sum beamformer
//
// usage: one req transaction carries four signed 32-bit mic samples; one
// rsp transaction returns the saturated beam sample. csr_ writes set the
// per-mic Q15 gains (index 0..3) and fractional delays (index 4..7); a
// delay above (LINE_LENGTH-2) << FRACTION_BITS is clamped on write.
// each frame runs through a small sequencer that shares one multiplier
// and one delay-line ram over the four mics: per mic the dc filter
// multiply, the gain multiply, the line write, two line reads and the
// interpolation multiply, then the output gain multiply.
// a new frame is taken only once the current one has posted its result,
// and req_ready is low meanwhile; a mic's first frame after reset skips
// the gain multiply.
// the result sits in an output register; while the receiver stalls the
// block still takes the next frame and stalls only before writing a new
// result over an untaken one.
// reset clears filter history, seed flags, write pointer and delay registers and sets the gains to unity.
// the delay lines reset to zero: after reset a clearing pass writes zeros
// to all 4*LINE_LENGTH entries, during which req_ready is low.
module four_mic_delay_sum_beamformer_core #(
   parameter int DC_ALPHA_Q31    = 2126008812,
   parameter int OUTPUT_GAIN_Q15 = 32768
) (
   input  logic                         clock,
   input  logic                         reset,
   fmdsb_stream_if.sink                 req,
   fmdsb_stream_if.source               rsp,
   input  logic                         csr_wr_en,
   input  logic [fmdsb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fmdsb_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import fmdsb_pkg::*;

   localparam int PTR_W  = $clog2(LINE_LENGTH);
   localparam int ADDR_W = PTR_W + 2;
   localparam int DEPTH  = MICS * LINE_LENGTH;
   localparam int MAX_DELAY = (LINE_LENGTH - 2) << FRACTION_BITS;
   localparam int GAIN_IDX0  = 0;
   localparam int DELAY_IDX0 = 4;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_FILT, S_FILT_W, S_GAIN, S_GAIN_W, S_WRITE,
      S_RD_NEW, S_RD_OLD, S_INTERP, S_INTERP_W, S_OUT, S_OUT_W, S_EMIT
   } state_type;

   state_type state_ff;
   gain_type   gain_ff   [MICS];
   delay_type  delay_ff  [MICS];
   sample_type prev_in_ff   [MICS];
   sample_type prev_filt_ff [MICS];
   logic [MICS-1:0] seeded_ff;
   logic [PTR_W-1:0] wptr_ff;
   logic [ADDR_W-1:0] clr_ff;
   logic [1:0] mic_ff;
   sample_type x_ff [MICS];
   sample_type y_ff;
   sample_type newer_ff;
   logic signed [35:0] sum_ff;
   sample_type beam_ff;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic emit_go;

   // shared multiplier
   logic signed [32:0] op_a, op_b;
   logic [4:0] mshift;
   logic signed [63:0] mprod;
   logic signed [63:0] mres;

   // ram
   logic ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

   logic [DELAY_W-1:0] cur_delay;
   logic [DELAY_W-FRACTION_BITS-1:0] whole;
   logic [FRACTION_BITS-1:0] frac;
   logic [PTR_W-1:0] ni, oi;
   logic signed [63:0] filt_sum;
   logic signed [35:0] avg;
   logic signed [63:0] delta;

   fmdsb_mac u_mac (
      .clock(clock), .op_a(op_a), .op_b(op_b), .shift(mshift),
      .prod_ff(mprod), .result(mres)
   );

   fmdsb_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_line (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
      .rd_addr(ram_raddr), .rd_data(ram_rdata)
   );

   // tap addresses for the current mic
   always_comb begin
      cur_delay = delay_ff[mic_ff];
      whole = cur_delay[DELAY_W-1:FRACTION_BITS];
      frac  = cur_delay[FRACTION_BITS-1:0];
      ni = PTR_W'(wptr_ff - PTR_W'(whole));
      oi = PTR_W'(ni - PTR_W'(1));
      // older entry sits in the read register, newer one in newer_ff
      delta = 64'($signed(ram_rdata)) - 64'(newer_ff);
      avg = sum_ff / 36'sd4;
      filt_sum = 64'(x_ff[mic_ff]) - 64'(prev_in_ff[mic_ff]) + mres;
      // post a result only once the previous one has been taken
      emit_go = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp.ready);
      rsp_valid_in = rsp_valid_ff;
      if (rsp.valid && rsp.ready) rsp_valid_in = 1'b0;
      if (emit_go) rsp_valid_in = 1'b1;
   end

   // multiplier operand and ram port select
   always_comb begin
      op_a = '0;
      op_b = '0;
      mshift = 5'(GAIN_SHIFT);
      ram_we = 1'b0;
      ram_waddr = {mic_ff, wptr_ff};
      ram_wdata = y_ff;
      ram_raddr = {mic_ff, ni};
      unique case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
         end
         S_FILT, S_FILT_W: begin
            op_a = 33'(DC_ALPHA_Q31);
            op_b = 33'(prev_filt_ff[mic_ff]);
            mshift = 5'(ALPHA_SHIFT);
         end
         S_GAIN, S_GAIN_W: begin
            op_a = 33'(y_ff);
            op_b = 33'(gain_ff[mic_ff]);
         end
         S_WRITE: ram_we = 1'b1;
         S_RD_OLD: ram_raddr = {mic_ff, oi};
         S_INTERP, S_INTERP_W: begin
            op_a = 33'(delta);
            op_b = 33'({1'b0, frac});
            mshift = 5'(FRACTION_BITS);
         end
         // operands held through emit so the product survives a stall
         S_OUT, S_OUT_W, S_EMIT: begin
            op_a = 33'(avg);
            op_b = 33'(OUTPUT_GAIN_Q15);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         seeded_ff <= '0;
         wptr_ff <= '0;
         mic_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MICS; i++) begin
            gain_ff[i] <= GAIN_W'(32768);
            delay_ff[i] <= '0;
            prev_in_ff[i] <= '0;
            prev_filt_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            if (int'(csr_index) < DELAY_IDX0) begin
               gain_ff[csr_index[1:0]] <= csr_wr_data;
            end else begin
               delay_ff[csr_index[1:0]] <= (int'(csr_wr_data[DELAY_W-1:0]) > MAX_DELAY)
                  ? DELAY_W'(MAX_DELAY) : csr_wr_data[DELAY_W-1:0];
            end
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= ADDR_W'(clr_ff + 1'b1);
               if (int'(clr_ff) == DEPTH - 1) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req.valid) begin
                  x_ff[0] <= req.payload[4*SAMPLE_W-1 -: SAMPLE_W];
                  x_ff[1] <= req.payload[3*SAMPLE_W-1 -: SAMPLE_W];
                  x_ff[2] <= req.payload[2*SAMPLE_W-1 -: SAMPLE_W];
                  x_ff[3] <= req.payload[SAMPLE_W-1 -: SAMPLE_W];
                  mic_ff <= '0;
                  sum_ff <= '0;
                  state_ff <= S_FILT;
               end
            end
            S_FILT: state_ff <= S_FILT_W;
            S_FILT_W: begin
               prev_in_ff[mic_ff] <= x_ff[mic_ff];
               if (!seeded_ff[mic_ff]) begin
                  seeded_ff[mic_ff] <= 1'b1;
                  prev_filt_ff[mic_ff] <= '0;
                  y_ff <= '0;
                  state_ff <= S_WRITE;
               end else begin
                  prev_filt_ff[mic_ff] <= sat32(filt_sum);
                  y_ff <= sat32(filt_sum);
                  state_ff <= S_GAIN;
               end
            end
            S_GAIN: state_ff <= S_GAIN_W;
            S_GAIN_W: begin
               y_ff <= sat32(mres);
               state_ff <= S_WRITE;
            end
            S_WRITE: state_ff <= S_RD_NEW;
            S_RD_NEW: state_ff <= S_RD_OLD;
            S_RD_OLD: begin
               newer_ff <= ram_rdata;
               state_ff <= S_INTERP;
            end
            S_INTERP: state_ff <= S_INTERP_W;
            S_INTERP_W: begin
               sum_ff <= sum_ff + 36'(sat32(64'(newer_ff) + mres));
               mic_ff <= 2'(mic_ff + 1'b1);
               state_ff <= (mic_ff == 2'(MICS - 1)) ? S_OUT : S_FILT;
            end
            S_OUT: state_ff <= S_OUT_W;
            S_OUT_W: state_ff <= S_EMIT;
            S_EMIT: begin
               if (emit_go) begin
                  beam_ff <= sat32(mres);
                  wptr_ff <= (int'(wptr_ff) == LINE_LENGTH - 1) ? '0
                             : PTR_W'(wptr_ff + 1'b1);
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req.ready   = (state_ff == S_IDLE);
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = beam_ff;

   // no frame accepted during the clearing pass
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req.ready) else $error("req ready during clear");
   // an untaken result is never overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(beam_ff))
      else $error("result lost while stalled");
   // write pointer moves only when a result is posted
   a_wptr: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff) != S_EMIT && !$past(reset) |-> $stable(wptr_ff))
      else $error("write pointer moved unexpectedly");
endmodule

// ===== tb/four_mic_delay_sum_beamformer_core_test.sv =====
// testbench for the four-mic delay-and-sum beamformer core: directed and random frames checked against a predictor
module four_mic_delay_sum_beamformer_core_test;
   import fmdsb_pkg::*;

   localparam int LINE_LEN   = 64;
   localparam int FRAC_BITS  = 8;
   localparam longint ALPHA  = 2126008812;
   localparam longint OUT_GAIN = 32768;
   localparam int MAX_DELAY  = (LINE_LEN - 2) << FRAC_BITS;
   localparam int STALL_LIMIT = 5000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GAIN0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DELAY0 = 3'd4;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   fmdsb_stream_if #(.WIDTH($bits(req_payload_type))) req_if ();
   fmdsb_stream_if #(.WIDTH($bits(rsp_payload_type))) rsp_if ();

   four_mic_delay_sum_beamformer_core uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // clock: period 10
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state, mirrors the block's registers and history
   longint   mic_gain [MICS];
   int       mic_delay [MICS];
   longint   hist_in [MICS];
   longint   hist_filt [MICS];
   bit [3:0] seeded;
   longint   line_store [MICS][LINE_LEN];
   int       wr_ptr;

   req_payload_type frames_to_send [$];
   sample_type      beam_expected [$];

   int  errors;
   int  frames_sent;
   int  beams_seen;
   int  csr_writes;
   int  cycle_count;
   int  quiet_cycles;
   bit  req_taken;

   function automatic longint round_away(longint v, int shift);
      longint r;
      r = longint'(1) << (shift - 1);
      if (v >= 0) return (v + r) >>> shift;
      return -(((-v) + r) >>> shift);
   endfunction

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // dc blocker plus calibration gain for one mic
   function automatic longint condition_mic(int m, longint x);
      longint y;
      if (!seeded[m]) begin
         hist_in[m] = x;
         hist_filt[m] = 0;
         seeded[m] = 1'b1;
         return 0;
      end
      y = clip32(x - hist_in[m] + round_away(ALPHA * hist_filt[m], ALPHA_SHIFT));
      hist_in[m] = x;
      hist_filt[m] = y;
      return clip32(round_away(y * mic_gain[m], GAIN_SHIFT));
   endfunction

   // linear interpolation between the two entries around the delay
   function automatic longint delayed_tap(int m);
      int whole;
      int frac;
      int ni;
      int oi;
      longint newer;
      longint older;
      whole = mic_delay[m] >> FRAC_BITS;
      frac = mic_delay[m] & ((1 << FRAC_BITS) - 1);
      ni = (wr_ptr + LINE_LEN - (whole % LINE_LEN)) % LINE_LEN;
      oi = (ni + LINE_LEN - 1) % LINE_LEN;
      newer = line_store[m][ni];
      older = line_store[m][oi];
      return clip32(newer + round_away((older - newer) * longint'(frac), FRAC_BITS));
   endfunction

   function automatic sample_type beam_of_frame(req_payload_type f);
      longint acc;
      longint avg;
      line_store[0][wr_ptr] = condition_mic(0, longint'(f.mic0_sample));
      line_store[1][wr_ptr] = condition_mic(1, longint'(f.mic1_sample));
      line_store[2][wr_ptr] = condition_mic(2, longint'(f.mic2_sample));
      line_store[3][wr_ptr] = condition_mic(3, longint'(f.mic3_sample));
      acc = 0;
      for (int m = 0; m < MICS; m++) acc += delayed_tap(m);
      wr_ptr = (wr_ptr + 1) % LINE_LEN;
      avg = clip32(acc / MICS);   // truncates toward zero
      return sample_type'(clip32(round_away(avg * OUT_GAIN, GAIN_SHIFT)));
   endfunction

   // idling: a break about 38 times in 100 calls, but none in a recurring stretch of full-rate traffic
   function automatic bit take_break();
      if ((cycle_count % 1000) < 180) return 1'b0;
      return $urandom_range(99) < 38;
   endfunction

   // initial values on every input
   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // driver: valid held until the transaction is taken
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !req_taken) begin
         req_if.valid <= 1'b1;
      end else if (frames_to_send.size() > 0 && !take_break()) begin
         req_if.payload <= frames_to_send.pop_front();
         req_if.valid <= 1'b1;
         frames_sent <= frames_sent + 1;
      end else begin
         req_if.valid <= 1'b0;
      end
      rsp_if.ready <= reset ? 1'b0 : !take_break();
   end

   // monitor: predict on each req transaction, check each rsp transaction
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            req_taken = 1'b1;
            beam_expected.push_back(beam_of_frame(req_payload_type'(req_if.payload)));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            beams_seen++;
            if (beam_expected.size() == 0) begin
               errors++;
               $display("%0t: beam_sample with none expected, actual %0d", $time,
                        $signed(rsp_if.payload));
            end else if (beam_expected[0] !== $signed(rsp_if.payload)) begin
               errors++;
               $display("%0t: beam_sample mismatch, expected %0d actual %0d", $time,
                        beam_expected[0], $signed(rsp_if.payload));
               void'(beam_expected.pop_front());
            end else begin
               void'(beam_expected.pop_front());
            end
         end
      end
   end

   // watchdog: long stretch with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("four_mic_delay_sum_beamformer_core test failed");
         $finish;
      end
   end

   // one register write, mirrored into the predictor; the delay clamps on write
   task automatic write_reg(input int idx, input logic [CSR_DATA_W-1:0] val);
      int d;
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = CSR_IDX_W'(idx);
      csr_wr_data = val;
      if (idx < REG_DELAY0) begin
         mic_gain[idx] = longint'($signed(val));
      end else begin
         d = int'(val[DELAY_W-1:0]);
         mic_delay[idx - REG_DELAY0] = (d > MAX_DELAY) ? MAX_DELAY : d;
      end
      csr_writes++;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // let the pipeline drain before touching registers
   task automatic wait_drained();
      wait (frames_to_send.size() == 0 && !req_if.valid && beam_expected.size() == 0);
      repeat (50) @(posedge clock);
   endtask

   function automatic sample_type pick_sample();
      case ($urandom_range(7))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return sample_type'($signed($urandom_range(0, 2000)) - 1000);
         3: return 32'sd0;
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_gain();
      case ($urandom_range(5))
         0: return 17'h10000;   // most negative
         1: return 17'h0FFFF;   // most positive
         2: return 17'h08000;   // unity
         3: return 17'h00000;
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_delay();
      case ($urandom_range(5))
         0: return 17'd0;
         1: return CSR_DATA_W'(MAX_DELAY);
         2: return 17'h1FFFF;   // above the maximum, clamps
         3: return CSR_DATA_W'($urandom_range(0, 3) << FRAC_BITS);
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   task automatic push_frame(input sample_type a, input sample_type b, input sample_type c,
                             input sample_type d);
      req_payload_type f;
      f.mic0_sample = a;
      f.mic1_sample = b;
      f.mic2_sample = c;
      f.mic3_sample = d;
      frames_to_send.push_back(f);
   endtask

   initial begin
      errors = 0;
      frames_sent = 0;
      beams_seen = 0;
      csr_writes = 0;
      cycle_count = 0;
      quiet_cycles = 0;
      req_taken = 1'b0;
      for (int m = 0; m < MICS; m++) begin
         mic_gain[m] = 32768;
         mic_delay[m] = 0;
         hist_in[m] = 0;
         hist_filt[m] = 0;
         for (int j = 0; j < LINE_LEN; j++) line_store[m][j] = 0;
      end
      seeded = '0;
      wr_ptr = 0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: unity gains, mixed delays incl. fraction and a clamped write
      write_reg(REG_DELAY0 + 0, 17'd0);
      write_reg(REG_DELAY0 + 1, 17'd384);          // one and a half samples
      write_reg(REG_DELAY0 + 2, CSR_DATA_W'(MAX_DELAY));
      write_reg(REG_DELAY0 + 3, 17'h03FFF);        // clamps to the maximum
      // first frame seeds the filters, then extremes and steps
      push_frame(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd5, -32'sd5);
      push_frame(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, 32'sd0);
      push_frame(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
      push_frame(32'sd0, 32'sd0, 32'sd0, 32'sd0);
      push_frame(32'shAAAA_AAAA, 32'sh5555_5555, 32'shFFFF_FFFF, 32'sd1);
      push_frame(32'sh5555_5555, 32'shAAAA_AAAA, 32'sd1, 32'shFFFF_FFFF);
      for (int k = 0; k < 6; k++) push_frame(32'sd1000, -32'sd1000, 32'sd3, -32'sd3);
      wait_drained();

      // directed: gain extremes so the gain stage saturates
      write_reg(REG_GAIN0 + 0, 17'h10000);
      write_reg(REG_GAIN0 + 1, 17'h0FFFF);
      write_reg(REG_GAIN0 + 2, 17'h00000);
      write_reg(REG_GAIN0 + 3, 17'h0FFFF);
      write_reg(REG_DELAY0 + 1, 17'd0);
      write_reg(REG_DELAY0 + 3, 17'd255);          // fraction only
      for (int k = 0; k < 8; k++)
         push_frame((k % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000,
                    (k % 2) ? 32'sh8000_0000 : 32'sh7FFF_FFFF,
                    sample_type'($urandom), sample_type'($urandom));
      wait_drained();

      // random phases, each with fresh settings
      for (int p = 0; p < 6; p++) begin
         for (int m = 0; m < MICS; m++) begin
            write_reg(REG_GAIN0 + m, pick_gain());
            write_reg(REG_DELAY0 + m, pick_delay());
         end
         for (int k = 0; k < 72; k++)
            push_frame(pick_sample(), pick_sample(), pick_sample(), pick_sample());
         wait_drained();
      end

      repeat (50) @(posedge clock);
      $display("covered %0d frames, %0d beam samples checked, %0d register writes",
               frames_sent, beams_seen, csr_writes);
      $display("settings spanned gain and delay extremes, clamped delays and saturation");
      if (errors == 0 && beam_expected.size() == 0) begin
         $display("four_mic_delay_sum_beamformer_core test passed");
      end else begin
         $display("%0d mismatches, %0d beam samples still expected", errors,
                  beam_expected.size());
         $display("four_mic_delay_sum_beamformer_core test failed");
      end
      $finish;
   end

endmodule
